// ===== design/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the STOMP frame parser
// Result item layout, role and error codes, character constants and the
// content-length key spelled out as a lookup function.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int MAX_HEADERS = 16;
  localparam int LENGTH_BITS = 32;
  localparam int HDR_BITS    = $clog2(MAX_HEADERS + 1);
  localparam int KEY_LEN     = 14;
  localparam int TDATA_BITS  = 48;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_GUARD =
    (LEN_MAX - LENGTH_BITS'(9)) / LENGTH_BITS'(10);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [2:0] ROLE_CMD   = 3'd0;
  localparam logic [2:0] ROLE_KEY   = 3'd1;
  localparam logic [2:0] ROLE_VALUE = 3'd2;
  localparam logic [2:0] ROLE_BODY  = 3'd3;
  localparam logic [2:0] ROLE_END   = 3'd4;
  localparam logic [2:0] ROLE_ERR   = 3'd5;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_COLON   = 2'd1;
  localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ERR_NO_NUL     = 2'd3;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  role;
    logic [4:0]  header_index;
    logic [1:0]  error_code;
    logic [31:0] body_length;
    logic        last;
  } res_t;

  // Up to two results caused by one input item; the first is always present.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

  function automatic logic [7:0] name_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/sfp_parse_core.sv =====
// ----------------------------------------------------------------------------
// sfp_parse_core: parser state and per-byte classification
// Holds the frame state and works out, for each accepted byte, the next
// state and the zero, one or two result items it causes.
// ----------------------------------------------------------------------------
module sfp_parse_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output sfp_pkg::pair_t pair
);
  import sfp_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CMD      = 3'd1;
  localparam logic [2:0] PH_HLINE    = 3'd2;
  localparam logic [2:0] PH_KEY      = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;
  localparam logic [2:0] PH_BODY_LEN = 3'd5;
  localparam logic [2:0] PH_BODY_NUL = 3'd6;
  localparam logic [2:0] PH_DROP     = 3'd7;

  typedef struct packed {
    logic [2:0]             phase;
    logic                   pending_cr;
    logic [HDR_BITS-1:0]    headers_seen;
    logic [3:0]             key_position;
    logic                   key_may_match;
    logic                   value_is_length;
    logic                   value_empty;
    logic                   length_known;
    logic [LENGTH_BITS-1:0] length_accumulator;
    logic [LENGTH_BITS-1:0] body_counter;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic emit;
    res_t res;
  } step_t;

  localparam st_t ST_RESET = '{
    phase:              PH_IDLE,
    pending_cr:         1'b0,
    headers_seen:       '0,
    key_position:       '0,
    key_may_match:      1'b1,
    value_is_length:    1'b0,
    value_empty:        1'b1,
    length_known:       1'b0,
    length_accumulator: '0,
    body_counter:       '0
  };

  st_t   state;
  st_t   state_next;
  pair_t pair_next;
  logic  any_next;

  function automatic res_t mk(logic [7:0] b, logic [2:0] role, logic [4:0] idx);
    res_t r;
    r              = '0;
    r.out_byte     = b;
    r.role         = role;
    r.header_index = idx;
    return r;
  endfunction

  function automatic step_t raise_error(st_t s, logic [1:0] code, logic [7:0] b);
    step_t r;
    r              = '0;
    r.st           = s;
    r.emit         = 1'b1;
    r.res.role     = ROLE_ERR;
    r.res.error_code = code;
    r.st.pending_cr  = 1'b0;
    r.st.phase       = (b == CH_NUL) ? PH_IDLE : PH_DROP;
    return r;
  endfunction

  function automatic st_t begin_line(st_t s);
    st_t n;
    n               = s;
    n.key_position  = '0;
    n.key_may_match = 1'b1;
    n.phase         = PH_HLINE;
    return n;
  endfunction

  // Content byte of the current line (never LF; a CR only when a held CR is released).
  function automatic step_t line_octet(st_t s, logic [7:0] b);
    step_t r;
    logic  bad;
    r      = '0;
    r.st   = s;
    bad    = 1'b0;
    if (s.phase == PH_CMD) begin
      r.emit = 1'b1;
      r.res  = mk(b, ROLE_CMD, 5'd0);
    end else if (s.phase == PH_HLINE || s.phase == PH_KEY) begin
      r.st.phase = PH_KEY;
      if (b == CH_COLON) begin
        r.st.value_is_length = s.key_may_match && (s.key_position == KEY_LEN) &&
                               !s.length_known && (s.headers_seen < MAX_HEADERS);
        r.st.value_empty        = 1'b1;
        r.st.length_accumulator = '0;
        r.st.phase              = PH_VALUE;
      end else begin
        if (s.key_may_match && (s.key_position < KEY_LEN) &&
            (b == name_char(s.key_position))) begin
          r.st.key_position = s.key_position + 4'd1;
        end else begin
          r.st.key_may_match = 1'b0;
        end
        r.emit = 1'b1;
        r.res  = mk(b, ROLE_KEY, 5'(s.headers_seen));
      end
    end else begin
      r.st.value_empty = 1'b0;
      if (s.value_is_length) begin
        bad = (b < CH_0) || (b > CH_9) || (s.length_accumulator > LEN_GUARD);
        if (bad) begin
          r = raise_error(r.st, ERR_BAD_LENGTH, b);
        end else begin
          r.st.length_accumulator = (s.length_accumulator << 3) +
                                    (s.length_accumulator << 1) +
                                    LENGTH_BITS'(b - CH_0);
        end
      end
      if (!bad) begin
        r.emit = 1'b1;
        r.res  = mk(b, ROLE_VALUE, 5'(s.headers_seen));
      end
    end
    return r;
  endfunction

  // LF that ends the current line.
  function automatic step_t end_line(st_t s, logic [7:0] b);
    step_t r;
    r    = '0;
    r.st = s;
    unique case (s.phase)
      PH_CMD: begin
        r.st = begin_line(s);
      end
      PH_HLINE: begin
        r.st.body_counter = '0;
        r.st.phase        = s.length_known ? PH_BODY_LEN : PH_BODY_NUL;
      end
      PH_KEY: begin
        r = raise_error(s, ERR_NO_COLON, b);
      end
      default: begin
        if (s.value_is_length && s.value_empty) begin
          r = raise_error(s, ERR_BAD_LENGTH, b);
        end else begin
          if (s.value_is_length) begin
            r.st.length_known = 1'b1;
          end
          if (s.headers_seen < MAX_HEADERS) begin
            r.st.headers_seen = s.headers_seen + HDR_BITS'(1);
          end
          r.st = begin_line(r.st);
        end
      end
    endcase
    return r;
  endfunction

  always_comb begin
    st_t   s;
    step_t t;
    logic  skip;
    s         = state;
    pair_next = '0;
    any_next  = 1'b0;
    skip      = 1'b0;
    t         = '0;
    unique case (state.phase)
      PH_IDLE: begin
        if (rx_byte != CH_CR && rx_byte != CH_LF) begin
          s.headers_seen       = '0;
          s.length_known       = 1'b0;
          s.length_accumulator = '0;
          s.value_is_length    = 1'b0;
          s.value_empty        = 1'b1;
          s.body_counter       = '0;
          s.pending_cr         = 1'b0;
          s.phase              = PH_CMD;
          any_next             = 1'b1;
          pair_next.r0         = mk(rx_byte, ROLE_CMD, 5'd0);
        end
      end
      PH_CMD, PH_HLINE, PH_KEY, PH_VALUE: begin
        if (s.pending_cr) begin
          s.pending_cr = 1'b0;
          if (rx_byte != CH_LF) begin
            // Release the held CR as content of the line first.
            t            = line_octet(s, CH_CR);
            s            = t.st;
            any_next     = t.emit;
            pair_next.r0 = t.res;
            if (s.phase == PH_DROP || s.phase == PH_IDLE) begin
              if (rx_byte == CH_NUL) begin
                s.phase = PH_IDLE;
              end
              skip = 1'b1;
            end
          end
        end
        if (!skip) begin
          t = '0;
          if (rx_byte == CH_CR) begin
            s.pending_cr = 1'b1;
          end else if (rx_byte == CH_LF) begin
            t = end_line(s, rx_byte);
            s = t.st;
          end else begin
            t = line_octet(s, rx_byte);
            s = t.st;
          end
          if (t.emit) begin
            if (any_next) begin
              pair_next.two = 1'b1;
              pair_next.r1  = t.res;
            end else begin
              pair_next.r0  = t.res;
            end
            any_next = 1'b1;
          end
        end
      end
      PH_BODY_LEN: begin
        any_next = 1'b1;
        if (s.body_counter < s.length_accumulator) begin
          s.body_counter = s.body_counter + LENGTH_BITS'(1);
          pair_next.r0   = mk(rx_byte, ROLE_BODY, 5'd0);
        end else if (rx_byte == CH_NUL) begin
          pair_next.r0             = mk(CH_NUL, ROLE_END, 5'd0);
          pair_next.r0.body_length = 32'(s.body_counter);
          s.phase                  = PH_IDLE;
        end else begin
          t            = raise_error(s, ERR_NO_NUL, rx_byte);
          s            = t.st;
          pair_next.r0 = t.res;
        end
      end
      PH_BODY_NUL: begin
        any_next = 1'b1;
        if (rx_byte == CH_NUL) begin
          pair_next.r0             = mk(CH_NUL, ROLE_END, 5'd0);
          pair_next.r0.body_length = 32'(s.body_counter);
          s.phase                  = PH_IDLE;
        end else begin
          if (s.body_counter != LEN_MAX) begin
            s.body_counter = s.body_counter + LENGTH_BITS'(1);
          end
          pair_next.r0 = mk(rx_byte, ROLE_BODY, 5'd0);
        end
      end
      default: begin
        if (rx_byte == CH_NUL) begin
          s.phase = PH_IDLE;
        end
      end
    endcase
    if (pair_next.two) begin
      pair_next.r1.last = 1'b1;
    end else begin
      pair_next.r0.last = 1'b1;
    end
    state_next = s;
  end

  assign push = accept && any_next;
  assign pair = pair_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

// ===== design/sfp_pair_fifo.sv =====
// ----------------------------------------------------------------------------
// sfp_pair_fifo: result queue
// Two-entry queue of result pairs; hands the results out one item at a time.
// ----------------------------------------------------------------------------
module sfp_pair_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfp_pkg::pair_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output sfp_pkg::res_t  out_data
);
  import sfp_pkg::*;

  pair_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       sel;
  logic       fire;
  logic       pop;
  pair_t      head;

  assign head      = entries[rd_ptr];
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = sel ? head.r1 : head.r0;
  assign fire      = out_valid && out_ready;
  // Retire the entry once its final result is taken.
  assign pop       = fire && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      sel    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        sel    <= 1'b0;
      end else if (fire) begin
        sel <= 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/stomp_frame_parser.sv =====
// ----------------------------------------------------------------------------
// stomp_frame_parser: STOMP 1.2 frame parser
// Classifies a raw STOMP byte stream into command, header, body, frame-end and error items.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side (s_tvalid/s_tready/s_tdata) takes one raw stream byte per
//   item. The master side returns classified items: the content byte, its
//   role in tuser (command, header key, header value, body, frame end,
//   error), the header number, an error code and, on frame end, the body
//   length. tlast marks the final result item caused by one input byte.
//   Most bytes cause one result; separators, line ends and dropped bytes
//   cause none unless a line end raises an error; a held CR released
//   before the next byte can cause two. A result waits in the queue until
//   the results ahead of it are taken. Throughput: one byte per cycle
//   while the queue has room, set by the combinational state update
//   (content-length multiply-add by ten, body counter compare).
//   Results wait in a two-entry queue of result pairs; s_tready drops only
//   when both entries are full, so a stalled receiver backs up the input
//   after two pending bytes and nothing is lost.
//   Reset (rst, synchronous) empties the queue and returns the parser to
//   idle, skipping CR/LF until the next frame starts.
// ----------------------------------------------------------------------------
module stomp_frame_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] out_byte, [12:8] header_index, [14:13] error_code,
  // [46:15] body_length, [47] zero
  output logic [sfp_pkg::TDATA_BITS-1:0] m_tdata,
  output logic [2:0]                     m_tuser,  // [2:0] role
  output logic                           m_tlast   // last
);
  import sfp_pkg::*;

  logic  accept;
  logic  push;
  logic  full;
  pair_t pair;
  res_t  res;

  // Take a byte whenever the queue has room for its results.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  sfp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .push    (push),
    .pair    (pair)
  );

  sfp_pair_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (pair),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // Pack the result item onto the master side.
  assign m_tdata = {1'b0, res.body_length, res.error_code, res.header_index, res.out_byte};
  assign m_tuser = res.role;
  assign m_tlast = res.last;

endmodule
